/* hw/rtl/ges_pkg.sv */
// Shared types and constants for the graph edge store.
// No dependencies; ges_if and csr_graph_edge_store use this package, ges_ram does not.
package ges_pkg;

  localparam int NODES     = 256;
  localparam int ENTRIES   = 1024;
  localparam int DEGREE    = 64;

  localparam int NODE_W    = 8;
  localparam int CNT_W     = 9;                        // node_count register
  localparam int ENTRY_W   = $clog2(ENTRIES + 1);      // 0..ENTRIES
  localparam int ST_AW     = $clog2(ENTRIES);
  localparam int SEG_AW    = $clog2(NODES + 1);
  localparam int CMD_W     = 3;
  localparam int STAT_W    = 3;
  localparam int EC_W      = 10;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 3'd0,
    CMD_QUERY  = 3'd1,
    CMD_LIST   = 3'd2,
    CMD_COUNT  = 3'd3,
    CMD_CLEAR  = 3'd4
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK     = 3'd0,
    ST_DUP    = 3'd1,
    ST_RANGE  = 3'd2,
    ST_FULL   = 3'd3,
    ST_DEGREE = 3'd4
  } status_t;

endpackage

/* hw/rtl/ges_if.sv */
// Command and result channel interfaces of the graph edge store.
// Depends on ges_pkg for field widths.
interface ges_cmd_if;
  logic                         valid;
  logic                         ready;
  logic [ges_pkg::CMD_W-1:0]    command;
  logic [ges_pkg::NODE_W-1:0]   node_a;
  logic [ges_pkg::NODE_W-1:0]   node_b;
  modport source (output valid, command, node_a, node_b, input ready);
  modport sink   (input valid, command, node_a, node_b, output ready);
endinterface

interface ges_res_if;
  logic                         valid;
  logic                         ready;
  logic [ges_pkg::STAT_W-1:0]   status;
  logic                         found;
  logic [ges_pkg::NODE_W-1:0]   neighbor;
  logic                         neighbor_valid;
  logic [ges_pkg::EC_W-1:0]     edge_count;
  logic                         last;
  modport source (output valid, status, found, neighbor, neighbor_valid, edge_count, last,
                  input ready);
  modport sink   (input valid, status, found, neighbor, neighbor_valid, edge_count, last,
                  output ready);
endinterface

/* hw/rtl/ges_ram.sv */
// Generic single-clock RAM, one write and one read port, registered read.
// No dependencies.
module ges_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

/* hw/rtl/csr_graph_edge_store.sv */
// Graph edge store: CSR adjacency held in a neighbor RAM and an offset RAM.
// Insert shifts the neighbor RAM up to open a slot, then bumps the following offsets,
// once for each endpoint; query scans a's neighbors and list streams them out.
// One command at a time; ready only while idle.
// Reset (synchronous, rst_n low) and clear run a pass zeroing all NODES + 1 offsets.
// Depends on ges_pkg, ges_if and ges_ram.
module csr_graph_edge_store (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [ges_pkg::CNT_W-1:0] cfg_wdata,
  ges_cmd_if.sink                   in_cmd,
  ges_res_if.source                 out_res
);
  import ges_pkg::*;

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_RD, S_SCAN_RD, S_SCAN_CMP, S_CHECK, S_SH, S_SH_WR,
    S_INC_RD, S_INC_WR, S_NEXT, S_LIST_RD, S_LIST_OUT, S_RESP
  } state_t;

  state_t               state_r, state_nxt;
  logic [CMD_W-1:0]     cmd_r, cmd_nxt;
  logic [NODE_W-1:0]    a_r, a_nxt, b_r, b_nxt, owner_r, owner_nxt, value_r, value_nxt;
  logic [2:0]           step_r, step_nxt;
  logic [ENTRY_W-1:0]   sa_r, sa_nxt, ea_r, ea_nxt, sb_r, sb_nxt, eb_r, eb_nxt;
  logic [ENTRY_W-1:0]   k_r, k_nxt, end_r, end_nxt, pos_r, pos_nxt, total_r, total_nxt;
  logic                 found_r, found_nxt, clr_cmd_r, clr_cmd_nxt, second_r, second_nxt;
  logic [STAT_W-1:0]    status_r, status_nxt;
  logic [CNT_W-1:0]     nc_r;

  logic                 out_valid_r, out_valid_nxt;
  logic [STAT_W-1:0]    out_status_r, out_status_nxt;
  logic                 out_found_r, out_found_nxt, out_nv_r, out_nv_nxt;
  logic                 out_last_r, out_last_nxt;
  logic [NODE_W-1:0]    out_nb_r, out_nb_nxt;
  logic [EC_W-1:0]      out_ec_r, out_ec_nxt;

  logic                 seg_we;
  logic [SEG_AW-1:0]    seg_waddr, seg_raddr;
  logic [ENTRY_W-1:0]   seg_wdata, seg_rdata;
  logic                 st_we;
  logic [ST_AW-1:0]     st_waddr, st_raddr;
  logic [NODE_W-1:0]    st_wdata, st_rdata;

  logic [CNT_W-1:0]     lim;
  logic                 a_oor, b_oor, accept, out_free, list_last;
  logic [ENTRY_W-1:0]   deg_a, deg_b, list_end;

  ges_ram #(.WIDTH(ENTRY_W), .DEPTH(NODES + 1)) u_seg_ram (
    .clk, .we(seg_we), .waddr(seg_waddr), .wdata(seg_wdata),
    .raddr(seg_raddr), .rdata(seg_rdata)
  );

  ges_ram #(.WIDTH(NODE_W), .DEPTH(ENTRIES)) u_store_ram (
    .clk, .we(st_we), .waddr(st_waddr), .wdata(st_wdata),
    .raddr(st_raddr), .rdata(st_rdata)
  );

  assign lim = (nc_r == '0) ? CNT_W'(1) :
               (nc_r > CNT_W'(NODES)) ? CNT_W'(NODES) : nc_r;
  assign a_oor    = {1'b0, in_cmd.node_a} >= lim;
  assign b_oor    = {1'b0, in_cmd.node_b} >= lim;
  assign accept   = in_cmd.valid && in_cmd.ready;
  assign out_free = !out_valid_r || out_res.ready;
  assign deg_a    = ea_r - sa_r;
  assign deg_b    = eb_r - sb_r;
  // clamp the listing to the degree bound
  assign list_end  = ((seg_rdata - sa_r) > ENTRY_W'(DEGREE)) ? sa_r + ENTRY_W'(DEGREE)
                                                             : seg_rdata;
  assign list_last = (k_r + ENTRY_W'(1)) == end_r;

  assign in_cmd.ready           = (state_r == S_IDLE);
  assign out_res.valid          = out_valid_r;
  assign out_res.status         = out_status_r;
  assign out_res.found          = out_found_r;
  assign out_res.neighbor       = out_nb_r;
  assign out_res.neighbor_valid = out_nv_r;
  assign out_res.edge_count     = out_ec_r;
  assign out_res.last           = out_last_r;

  always_comb begin
    state_nxt   = state_r;
    cmd_nxt     = cmd_r;
    a_nxt       = a_r;
    b_nxt       = b_r;
    owner_nxt   = owner_r;
    value_nxt   = value_r;
    step_nxt    = step_r;
    sa_nxt      = sa_r;
    ea_nxt      = ea_r;
    sb_nxt      = sb_r;
    eb_nxt      = eb_r;
    k_nxt       = k_r;
    end_nxt     = end_r;
    pos_nxt     = pos_r;
    total_nxt   = total_r;
    found_nxt   = found_r;
    clr_cmd_nxt = clr_cmd_r;
    second_nxt  = second_r;
    status_nxt  = status_r;

    out_valid_nxt  = out_valid_r && !out_res.ready;
    out_status_nxt = out_status_r;
    out_found_nxt  = out_found_r;
    out_nb_nxt     = out_nb_r;
    out_nv_nxt     = out_nv_r;
    out_ec_nxt     = out_ec_r;
    out_last_nxt   = out_last_r;

    seg_we    = 1'b0;
    seg_waddr = k_r[SEG_AW-1:0];
    seg_wdata = '0;
    seg_raddr = k_r[SEG_AW-1:0];
    st_we     = 1'b0;
    st_waddr  = k_r[ST_AW-1:0];
    st_wdata  = value_r;
    st_raddr  = k_r[ST_AW-1:0];

    case (state_r)
      S_CLR: begin
        seg_we = 1'b1;
        if (k_r == ENTRY_W'(NODES)) begin
          total_nxt = '0;
          if (clr_cmd_r) begin
            status_nxt = ST_OK;
            found_nxt  = 1'b0;
            state_nxt  = S_RESP;
          end else begin
            state_nxt = S_IDLE;
          end
        end else begin
          k_nxt = k_r + ENTRY_W'(1);
        end
      end
      S_IDLE: begin
        if (accept) begin
          cmd_nxt    = in_cmd.command;
          a_nxt      = in_cmd.node_a;
          b_nxt      = in_cmd.node_b;
          found_nxt  = 1'b0;
          status_nxt = ST_OK;
          step_nxt   = '0;
          case (in_cmd.command)
            CMD_INSERT, CMD_QUERY: begin
              if (a_oor || b_oor) begin
                status_nxt = ST_RANGE;
                state_nxt  = S_RESP;
              end else begin
                state_nxt = S_RD;
              end
            end
            CMD_LIST: begin
              if (a_oor) begin
                status_nxt = ST_RANGE;
                state_nxt  = S_RESP;
              end else begin
                state_nxt = S_RD;
              end
            end
            CMD_COUNT: state_nxt = S_RESP;
            CMD_CLEAR: begin
              k_nxt       = '0;
              clr_cmd_nxt = 1'b1;
              state_nxt   = S_CLR;
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_RD: begin
        // fetch start/end offsets of a, then of b; read data is registered
        case (step_r)
          3'd0:    seg_raddr = {1'b0, a_r};
          3'd1:    seg_raddr = {1'b0, a_r} + SEG_AW'(1);
          3'd2:    seg_raddr = {1'b0, b_r};
          default: seg_raddr = {1'b0, b_r} + SEG_AW'(1);
        endcase
        step_nxt = step_r + 3'd1;
        case (step_r)
          3'd1: sa_nxt = seg_rdata;
          3'd2: begin
            ea_nxt = seg_rdata;
            if (cmd_r == CMD_QUERY) begin
              k_nxt     = sa_r;
              state_nxt = S_SCAN_RD;
            end else if (cmd_r == CMD_LIST) begin
              k_nxt   = sa_r;
              end_nxt = list_end;
              if (sa_r >= list_end) begin
                state_nxt = S_RESP;
              end else begin
                state_nxt = S_LIST_RD;
              end
            end
          end
          3'd3: sb_nxt = seg_rdata;
          3'd4: begin
            eb_nxt    = seg_rdata;
            k_nxt     = sa_r;
            state_nxt = S_SCAN_RD;
          end
          default: ;
        endcase
      end
      S_SCAN_RD: begin
        if (k_r == ea_r) begin
          state_nxt = (cmd_r == CMD_QUERY) ? S_RESP : S_CHECK;
        end else begin
          state_nxt = S_SCAN_CMP;
        end
      end
      S_SCAN_CMP: begin
        if (st_rdata == b_r) begin
          found_nxt = 1'b1;
          state_nxt = (cmd_r == CMD_QUERY) ? S_RESP : S_CHECK;
        end else begin
          k_nxt     = k_r + ENTRY_W'(1);
          state_nxt = S_SCAN_RD;
        end
      end
      S_CHECK: begin
        found_nxt = 1'b0;
        state_nxt = S_RESP;
        if (found_r) begin
          status_nxt = ST_DUP;
        end else if (total_r + ENTRY_W'(2) > ENTRY_W'(ENTRIES)) begin
          status_nxt = ST_FULL;
        end else if ((a_r == b_r) ? (deg_a + ENTRY_W'(2) > ENTRY_W'(DEGREE))
                                  : ((deg_a + ENTRY_W'(1) > ENTRY_W'(DEGREE)) ||
                                     (deg_b + ENTRY_W'(1) > ENTRY_W'(DEGREE)))) begin
          status_nxt = ST_DEGREE;
        end else begin
          owner_nxt  = a_r;
          value_nxt  = b_r;
          pos_nxt    = sa_r;
          k_nxt      = total_r;
          second_nxt = 1'b0;
          state_nxt  = S_SH;
        end
      end
      S_SH: begin
        if (k_r == pos_r) begin
          st_we     = 1'b1;
          k_nxt     = {{(ENTRY_W - NODE_W){1'b0}}, owner_r} + ENTRY_W'(1);
          state_nxt = S_INC_RD;
        end else begin
          st_raddr  = st_waddr - ST_AW'(1);
          state_nxt = S_SH_WR;
        end
      end
      S_SH_WR: begin
        // move the word just read up by one slot
        st_we     = 1'b1;
        st_wdata  = st_rdata;
        k_nxt     = k_r - ENTRY_W'(1);
        state_nxt = S_SH;
      end
      S_INC_RD: state_nxt = S_INC_WR;
      S_INC_WR: begin
        seg_we    = 1'b1;
        seg_wdata = seg_rdata + ENTRY_W'(1);
        if (k_r == ENTRY_W'(NODES)) begin
          total_nxt = total_r + ENTRY_W'(1);
          state_nxt = S_NEXT;
        end else begin
          k_nxt     = k_r + ENTRY_W'(1);
          state_nxt = S_INC_RD;
        end
      end
      S_NEXT: begin
        if (!second_r) begin
          second_nxt = 1'b1;
          owner_nxt  = b_r;
          value_nxt  = a_r;
          // b's start moved up if it lies after a
          pos_nxt    = (b_r > a_r) ? sb_r + ENTRY_W'(1) : ((b_r == a_r) ? sa_r : sb_r);
          k_nxt      = total_r;
          state_nxt  = S_SH;
        end else begin
          status_nxt = ST_OK;
          state_nxt  = S_RESP;
        end
      end
      S_LIST_RD: state_nxt = S_LIST_OUT;
      S_LIST_OUT: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_OK;
          out_found_nxt  = 1'b0;
          out_nb_nxt     = st_rdata;
          out_nv_nxt     = 1'b1;
          out_ec_nxt     = total_r[ENTRY_W-1:1];
          out_last_nxt   = list_last;
          if (list_last) begin
            state_nxt = S_IDLE;
          end else begin
            k_nxt     = k_r + ENTRY_W'(1);
            state_nxt = S_LIST_RD;
          end
        end
      end
      S_RESP: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = status_r;
          out_found_nxt  = found_r;
          out_nb_nxt     = '0;
          out_nv_nxt     = 1'b0;
          out_ec_nxt     = total_r[ENTRY_W-1:1];
          out_last_nxt   = 1'b1;
          clr_cmd_nxt    = 1'b0;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      k_r         <= '0;
      clr_cmd_r   <= 1'b0;
      second_r    <= 1'b0;
      total_r     <= '0;
      nc_r        <= CNT_W'(NODES);
      out_valid_r <= 1'b0;
      step_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      k_r         <= k_nxt;
      clr_cmd_r   <= clr_cmd_nxt;
      second_r    <= second_nxt;
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
      step_r      <= step_nxt;
      if (cfg_we) begin
        nc_r <= cfg_wdata;
      end
    end
    cmd_r        <= cmd_nxt;
    a_r          <= a_nxt;
    b_r          <= b_nxt;
    owner_r      <= owner_nxt;
    value_r      <= value_nxt;
    sa_r         <= sa_nxt;
    ea_r         <= ea_nxt;
    sb_r         <= sb_nxt;
    eb_r         <= eb_nxt;
    end_r        <= end_nxt;
    pos_r        <= pos_nxt;
    found_r      <= found_nxt;
    status_r     <= status_nxt;
    out_status_r <= out_status_nxt;
    out_found_r  <= out_found_nxt;
    out_nb_r     <= out_nb_nxt;
    out_nv_r     <= out_nv_nxt;
    out_ec_r     <= out_ec_nxt;
    out_last_r   <= out_last_nxt;
  end

`ifndef SYNTHESIS
  a_count_resp: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (in_cmd.command == CMD_COUNT) |=> state_r == S_RESP)
    else $error("count command did not go straight to response");

  a_even_total: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !total_r[0])
    else $error("entry total odd between commands");

  a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
    total_r <= ENTRY_W'(ENTRIES))
    else $error("entry total beyond store depth");
`endif
endmodule
